// ===== design/edd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the error diffusion dither unit
// no dependencies
package edd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WM_W   = COL_W + 1;
  localparam int DIM_W  = 12;
  localparam int EXT_W  = (DIM_W > COL_W + 1) ?
                          ((DIM_W > ROW_W + 1) ? DIM_W : ROW_W + 1) :
                          ((COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1);
  localparam int GRAY_W = 8;
  localparam int FRAC_W = 4;
  localparam int ERR_W  = 16;
  localparam int SUM_W  = ERR_W + 2;
  localparam int E_W    = ERR_W + 1;
  localparam int P_W    = E_W + 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd512;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd512;

  localparam logic signed [ERR_W-1:0] THRESH    = 16'sd2032;  // 127.0
  localparam logic signed [ERR_W-1:0] WHITE_OFS = 16'sd4080;  // 255.0
  localparam logic signed [ERR_W-1:0] ERR_MAX   = 16'sh7fff;
  localparam logic signed [ERR_W-1:0] ERR_MIN   = 16'sh8000;

  typedef logic signed [ERR_W-1:0] err_t;

  // position of one pixel inside the frame
  typedef struct packed {
    logic [COL_W-1:0] x;
    logic             first_col;
    logic             frame_start;
    logic             last_col;
    logic             last_row;
  } pos_t;

  // one write into the next-row error store
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    err_t             data;
  } err_wr_t;

  function automatic err_t sat16(input logic signed [SUM_W-1:0] v);
    err_t r;
    if (v > SUM_W'(ERR_MAX)) begin
      r = ERR_MAX;
    end else if (v < SUM_W'(ERR_MIN)) begin
      r = ERR_MIN;
    end else begin
      r = ERR_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/edd_pos.sv =====
`timescale 1ns / 1ps
// raster position counters with clamping of the frame size registers
// depends on edd_pkg
module edd_pos import edd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output pos_t             pos
);

  logic [COL_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] last_x;
  logic [ROW_W-1:0] last_y;
  logic [EXT_W-1:0] w_ext, h_ext;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;

  always_comb begin
    w_ext = EXT_W'(image_width);
    h_ext = EXT_W'(image_height);
    // zero acts as one, oversize acts as the maximum
    if (image_width == '0) begin
      last_x = '0;
    end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
      last_x = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_x = COL_W'(w_ext - EXT_W'(1));
    end
    if (image_height == '0) begin
      last_y = '0;
    end else if (h_ext > EXT_W'(MAX_HEIGHT)) begin
      last_y = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_y = ROW_W'(h_ext - EXT_W'(1));
    end
    x = (column_count_r >= last_x) ? last_x : column_count_r;
    y = (row_count_r >= last_y) ? last_y : row_count_r;
    pos.x           = x;
    pos.first_col   = (x == '0);
    pos.frame_start = (x == '0) && (y == '0);
    pos.last_col    = (x == last_x);
    pos.last_row    = (y == last_y);
  end

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (accept) begin
      if (pos.last_col) begin
        column_count_nxt = '0;
        row_count_nxt    = pos.last_row ? '0 : y + ROW_W'(1);
      end else begin
        column_count_nxt = x + COL_W'(1);
        row_count_nxt    = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

endmodule

// ===== design/edd_lstore.sv =====
`timescale 1ns / 1ps
// next-row error store: line memory, deferred row-end write, bypass, written-prefix mark
// depends on edd_pkg
module edd_lstore import edd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             hold,
  input  logic [COL_W-1:0] hold_addr,
  input  logic             proc,
  input  pos_t             proc_pos,
  input  err_wr_t          wr_prim,
  input  err_wr_t          wr_last,
  output err_t             row_err,
  output logic             wr_clash
);

  err_t             mem [MAX_WIDTH];
  err_t             rd_data_r;
  logic             fwd_hit_r, fwd_hit_nxt;
  err_t             fwd_data_r, fwd_data_nxt;
  err_wr_t          def_r, def_nxt;
  logic [WM_W-1:0]  wm_r, wm_nxt;
  logic [WM_W-1:0]  wm_base, wm_cand;
  err_wr_t          mw;
  logic             drain;
  logic             entry_valid;
  err_t             raw;

  // row-end write is deferred until no regular write is made; the next pixel is always column 0
  always_comb begin
    drain = def_r.en && !wr_prim.en;
    mw    = wr_prim.en ? wr_prim : def_r;
    mw.en = wr_prim.en || def_r.en;
    wr_clash = wr_prim.en && def_r.en;
    def_nxt = def_r;
    if (wr_last.en) begin
      def_nxt = wr_last;
    end else if (drain) begin
      def_nxt.en = 1'b0;
    end
  end

  // catch writes that land after the registered read was taken
  always_comb begin
    fwd_hit_nxt  = fwd_hit_r;
    fwd_data_nxt = fwd_data_r;
    if (rd_en) begin
      fwd_hit_nxt  = mw.en && (mw.addr == rd_addr);
      fwd_data_nxt = mw.data;
    end else if (hold && mw.en && (mw.addr == hold_addr)) begin
      fwd_hit_nxt  = 1'b1;
      fwd_data_nxt = mw.data;
    end
  end

  // entries below the mark were written in this frame, the rest read as zero
  always_comb begin
    wm_base     = proc_pos.frame_start ? '0 : wm_r;
    wm_cand     = proc_pos.last_col ? WM_W'(proc_pos.x) + WM_W'(1) : WM_W'(proc_pos.x);
    wm_nxt      = proc ? ((wm_cand > wm_base) ? wm_cand : wm_base) : wm_r;
    entry_valid = WM_W'(proc_pos.x) < wm_base;
    if (def_r.en && (def_r.addr == proc_pos.x)) begin
      raw = def_r.data;
    end else if (fwd_hit_r) begin
      raw = fwd_data_r;
    end else begin
      raw = rd_data_r;
    end
    row_err = entry_valid ? raw : '0;
  end

  always_ff @(posedge clk) begin
    if (mw.en) begin
      mem[mw.addr] <= mw.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    fwd_data_r    <= fwd_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
      def_r.en  <= 1'b0;
      wm_r      <= '0;
    end else begin
      fwd_hit_r <= fwd_hit_nxt;
      def_r     <= def_nxt;
      wm_r      <= wm_nxt;
    end
  end

endmodule

// ===== design/edd_diff.sv =====
`timescale 1ns / 1ps
// threshold and error spreading for one pixel, with the in-row carry registers
// depends on edd_pkg
module edd_diff import edd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  pos_t              pos,
  input  logic [GRAY_W-1:0] gray,
  input  err_t              row_err,
  output logic              white,
  output err_wr_t           wr_prim,
  output err_wr_t           wr_last
);

  err_t                    right_carry_r, right_carry_nxt;
  err_t                    pend_dl_r, pend_dl_nxt;
  err_t                    pend_d_r, pend_d_nxt;
  err_t                    rc, pdl, pd;
  err_t                    v1, v;
  logic signed [E_W-1:0]   e;
  logic signed [P_W-1:0]   ex, p7, p3, p5;
  err_t                    d7, d3, d5, d1;
  logic                    spread;

  always_comb begin
    rc  = pos.first_col ? '0 : right_carry_r;
    pdl = pos.first_col ? '0 : pend_dl_r;
    pd  = pos.first_col ? '0 : pend_d_r;

    v1    = sat16($signed(SUM_W'({gray, {FRAC_W{1'b0}}})) + SUM_W'(rc));
    v     = sat16(SUM_W'(v1) + SUM_W'(row_err));
    white = v > THRESH;
    e     = white ? (E_W'(v) - E_W'(WHITE_OFS)) : E_W'(v);

    // shares by shift and add, floored by the arithmetic shift
    ex = P_W'(e);
    p7 = (ex <<< 3) - ex;
    p3 = (ex <<< 1) + ex;
    p5 = (ex <<< 2) + ex;
    spread = !pos.last_row && !pos.first_col && !pos.last_col;
    d7 = spread ? ERR_W'(p7 >>> FRAC_W) : '0;
    d3 = spread ? ERR_W'(p3 >>> FRAC_W) : '0;
    d5 = spread ? ERR_W'(p5 >>> FRAC_W) : '0;
    d1 = spread ? ERR_W'(ex >>> FRAC_W) : '0;

    pend_dl_nxt     = proc ? sat16(SUM_W'(pd) + SUM_W'(d5)) : pend_dl_r;
    pend_d_nxt      = proc ? d1 : pend_d_r;
    right_carry_nxt = proc ? d7 : right_carry_r;

    wr_prim.en   = proc && !pos.first_col;
    wr_prim.addr = pos.x - COL_W'(1);
    wr_prim.data = sat16(SUM_W'(pdl) + SUM_W'(d3));

    wr_last.en   = proc && pos.last_col;
    wr_last.addr = pos.x;
    wr_last.data = sat16(SUM_W'(pd) + SUM_W'(d5));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_carry_r <= '0;
      pend_dl_r     <= '0;
      pend_d_r      <= '0;
    end else begin
      right_carry_r <= right_carry_nxt;
      pend_dl_r     <= pend_dl_nxt;
      pend_d_r      <= pend_d_nxt;
    end
  end

endmodule

// ===== design/error_diffusion_dither_unit.sv =====
`timescale 1ns / 1ps
// top level of the error diffusion dither unit
// depends on edd_pkg, edd_pos, edd_lstore, edd_diff
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall    in_gray_pixel[7:0]
//  out_     output     out_valid / out_stall  out_bw_pixel, out_end_of_frame
//  cfg_     input      cfg_valid / cfg_ready  cfg_index[0], cfg_wdata[11:0]
//
// one pixel per clock sustained while out_stall is low
// the line store read (registered memory port) sets the first stage, the
// threshold and spread arithmetic the second
// no clearing pass: a written-prefix mark makes the store read zero after frame start
// synchronous active-low reset returns both size registers to 512 and the position to 0
// out_stall holds the result register and the working stage, which stalls the input
module error_diffusion_dither_unit import edd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [GRAY_W-1:0]    in_gray_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_bw_pixel,
  output logic                 out_end_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  // frame size registers
  logic [DIM_W-1:0] image_width_r, image_width_nxt;
  logic [DIM_W-1:0] image_height_r, image_height_nxt;

  // working stage, holds the pixel while its line store word is read
  logic              s1_valid_r, s1_valid_nxt;
  pos_t              s1_pos_r;
  logic [GRAY_W-1:0] s1_gray_r;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_bw_r, out_eof_r;

  logic    accept, advance, hold;
  pos_t    in_pos;
  err_t    row_err;
  logic    white;
  err_wr_t wr_prim, wr_last;
  logic    wr_clash;

  assign cfg_ready = 1'b1;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // the working stage moves on when the result register is free or being taken
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign hold     = s1_valid_r && !advance;
  assign in_stall = hold;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  edd_pos u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .pos          (in_pos)
  );

  edd_lstore u_lstore (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (in_pos.x),
    .hold      (hold),
    .hold_addr (s1_pos_r.x),
    .proc      (advance),
    .proc_pos  (s1_pos_r),
    .wr_prim   (wr_prim),
    .wr_last   (wr_last),
    .row_err   (row_err),
    .wr_clash  (wr_clash)
  );

  edd_diff u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (advance),
    .pos     (s1_pos_r),
    .gray    (s1_gray_r),
    .row_err (row_err),
    .white   (white),
    .wr_prim (wr_prim),
    .wr_last (wr_last)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= in_pos;
      s1_gray_r <= in_gray_pixel;
    end
    if (advance) begin
      out_bw_r  <= white;
      out_eof_r <= s1_pos_r.last_col && s1_pos_r.last_row;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bw_pixel     = out_bw_r;
  assign out_end_of_frame = out_eof_r;

  // the deferred row-end write never meets a regular write
  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_clash)
    else $error("line store write clash");

  // an empty working stage always takes a word
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty working stage");

  // a stalled result keeps the working pixel in place
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_pos_r))
    else $error("working stage lost under stall");

  // a fresh result only follows a pixel leaving the working stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r && out_stall) |-> $past(advance))
    else $error("result appeared without a processed pixel");

endmodule

// ===== tb/sv/tb_error_diffusion_dither_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for error_diffusion_dither_unit: directed and random frames
// checked against an in-bench floyd-steinberg predictor; depends on edd_pkg and the design
module tb_error_diffusion_dither_unit;
  import edd_pkg::*;

  // fixed point: 1.0 is 16, threshold 127.0, white level 255.0
  localparam int FRAC_ONE    = 16;
  localparam int THRESHOLD   = 127 * FRAC_ONE;
  localparam int FULL_WHITE  = 255 * FRAC_ONE;
  localparam int NUM_RANDOM  = 380;
  localparam int SETTLE_CYC  = 4;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_PERIODIC} stall_mode_t;

  typedef enum int {GRAY_UNIFORM, GRAY_EXTREME, GRAY_NEAR_THRESH, GRAY_FLAT, GRAY_RAMP}
    gray_style_t;

  // one expected output word
  typedef struct packed {
    logic bw;
    logic eof;
  } dither_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [GRAY_W-1:0]    in_gray_pixel;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_bw_pixel;
  logic                 out_end_of_frame;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  error_diffusion_dither_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_gray_pixel    (in_gray_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bw_pixel     (out_bw_pixel),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor state: mirrored size registers and the dither state
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
  logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
  int below_err [MAX_WIDTH];   // error waiting for the row below
  int right_carry;             // 7/16 share for the next pixel of the row
  int pend_down_left;          // partial sum for column x-1 of the next row
  int pend_down;               // 1/16 share for column x of the next row
  int col_pos;
  int row_pos;

  dither_word_t expected_words [$];
  int           mismatch_count;

  // stimulus pacing
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_run   = 0;
  int          cycle_count = 0;
  bit          sender_gaps = 1'b0;
  int          burst_left  = 1;

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // a zero register acts as 1, an oversize one as the limit
  function automatic int usable_size(input logic [DIM_W-1:0] r, input int limit);
    if (r == 0) return 1;
    if (int'(r) > limit) return limit;
    return int'(r);
  endfunction

  // works out the dithered word for one accepted gray pixel and advances the state
  task automatic dither_pixel(input logic [GRAY_W-1:0] gray, output dither_word_t word);
    int w, h, x, y, v, e, d7, d3, d5, d1;
    bit last_col, last_row, white;
    w = usable_size(width_reg, MAX_WIDTH);
    h = usable_size(height_reg, MAX_HEIGHT);
    // positions left beyond a shrunk frame are pinned to the last column / row
    x = (col_pos >= w - 1) ? w - 1 : col_pos;
    y = (row_pos >= h - 1) ? h - 1 : row_pos;
    last_col = (x == w - 1);
    last_row = (y == h - 1);
    d7 = 0;
    d3 = 0;
    d5 = 0;
    d1 = 0;
    if (x == 0) begin
      // frame start wipes the store, row start restarts the running shares
      if (y == 0) begin
        foreach (below_err[i]) below_err[i] = 0;
      end
      right_carry    = 0;
      pend_down_left = 0;
      pend_down      = 0;
    end
    v = clamp16(int'(gray) * FRAC_ONE + right_carry);
    v = clamp16(v + below_err[x]);
    white = (v > THRESHOLD);
    e = white ? v - FULL_WHITE : v;
    // the left and right edges and the last row take error but pass none on
    if (!last_row && x >= 1 && !last_col) begin
      d7 = (e * 7) >>> 4;
      d3 = (e * 3) >>> 4;
      d5 = (e * 5) >>> 4;
      d1 = e >>> 4;
    end
    right_carry = d7;
    if (x >= 1) below_err[x-1] = clamp16(pend_down_left + d3);
    pend_down_left = clamp16(pend_down + d5);
    pend_down      = d1;
    if (last_col) below_err[x] = pend_down_left;
    word.bw  = white;
    word.eof = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side: one gray pixel per call, bursts with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_gray(input logic [GRAY_W-1:0] gray);
    dither_word_t word;
    int gap;
    in_valid      <= 1'b1;
    in_gray_pixel <= gray;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    dither_pixel(gray, word);
    expected_words.push_back(word);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and let every outstanding word drain
  task automatic settle;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // register write; only called with the block idle
  task automatic write_size(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic resize(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_size(REG_IMAGE_WIDTH, w);
    write_size(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [GRAY_W-1:0] pick_gray(input gray_style_t style, input int k,
                                                  input logic [GRAY_W-1:0] base);
    case (style)
      GRAY_EXTREME:     return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      GRAY_NEAR_THRESH: return GRAY_W'($urandom_range(120, 136));
      GRAY_FLAT:        return base;
      GRAY_RAMP:        return GRAY_W'(int'(base) + k * 3);
      default:          return GRAY_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall pattern and word check
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    dither_word_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 1);
      end else begin
        want = expected_words.pop_front();
        if (out_bw_pixel !== want.bw) report_mismatch("bw_pixel", want.bw, out_bw_pixel);
        if (out_end_of_frame !== want.eof)
          report_mismatch("end_of_frame", want.eof, out_end_of_frame);
      end
    end
    // stall pattern for the next edge
    case (stall_mode)
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_BURSTY: begin
        if (stall_run > 0) begin
          stall_run <= stall_run - 1;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_run <= $urandom_range(1, 15);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
      STALL_PERIODIC: begin
        out_stall <= (cycle_count % 5) >= 3;
      end
      default: begin
        out_stall <= 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a few pixels at the power-on size of 512 x 512, left mid-row on purpose
  task automatic test_power_on_size;
    stall_mode  = STALL_NONE;
    sender_gaps = 1'b0;
    send_gray(8'd0);
    send_gray(8'd255);
    send_gray(8'd128);
  endtask

  // twelve pixels around the threshold at a 4 x 3 size; the resize lands mid-frame
  task automatic test_threshold_frame;
    logic [GRAY_W-1:0] pix [12];
    pix = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd128, 8'd127, 8'd255, 8'd0,
            8'd200, 8'd50, 8'd120, 8'd136};
    resize(12'd4, 12'd3);
    stall_mode  = STALL_RANDOM;
    sender_gaps = 1'b1;
    foreach (pix[i]) send_gray(pix[i]);
  endtask

  // zero registers act as a 1 x 1 frame: every word ends a frame
  task automatic test_zero_size;
    resize(12'd0, 12'd0);
    stall_mode = STALL_PERIODIC;
    send_gray(8'd127);
    send_gray(8'd128);
    send_gray(8'd255);
  endtask

  // oversize and full-width registers, then shrinking below the current position
  task automatic test_oversize_regs;
    resize(12'd4095, 12'd4095);
    stall_mode  = STALL_BURSTY;
    sender_gaps = 1'b1;
    repeat (30) send_gray(GRAY_W'($urandom));
    settle();
    write_size(REG_IMAGE_WIDTH, 12'd2048);
    repeat (10) send_gray(GRAY_W'($urandom));
    // column beyond the new last column: next pixel ends the row
    settle();
    write_size(REG_IMAGE_WIDTH, 12'd7);
    stall_mode = STALL_NONE;
    repeat (10) send_gray(GRAY_W'($urandom));
    // row beyond the new last row: this row ends the frame
    settle();
    write_size(REG_IMAGE_HEIGHT, 12'd1);
    repeat (8) send_gray(GRAY_W'($urandom));
  endtask

  // single-column frames at full height, then height cut to one row mid-frame
  task automatic test_tall_column;
    resize(12'd1, 12'd2048);
    stall_mode  = STALL_RANDOM;
    sender_gaps = 1'b0;
    repeat (40) send_gray(GRAY_W'($urandom));
    settle();
    write_size(REG_IMAGE_HEIGHT, 12'd0);
    repeat (4) send_gray(GRAY_W'($urandom));
  endtask

  // random frame sizes, content styles and pacing; mostly small whole frames
  task automatic test_random_frames;
    int accepted, sel, w, h, area, n;
    gray_style_t style;
    logic [GRAY_W-1:0] base;
    accepted = 0;
    while (accepted < NUM_RANDOM) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 8);
      end else if (sel == 7) begin
        w = $urandom_range(17, 64);
        h = $urandom_range(1, 3);
      end else if (sel == 8) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        h = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
      end else begin
        w = $urandom_range(2, 12);
        h = $urandom_range(2, 6);
      end
      resize(DIM_W'(w), DIM_W'(h));
      stall_mode  = stall_mode_t'($urandom_range(0, 3));
      sender_gaps = ($urandom_range(0, 3) != 0);
      area = usable_size(width_reg, MAX_WIDTH) * usable_size(height_reg, MAX_HEIGHT);
      // the last choice may stop part way so the next resize hits mid-frame
      n = (sel == 9) ? $urandom_range(1, area) : area * $urandom_range(1, 2);
      style = gray_style_t'($urandom_range(0, 4));
      base  = GRAY_W'($urandom);
      for (int k = 0; k < n; k++) begin
        send_gray(pick_gray(style, k, base));
        accepted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_gray_pixel  <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_IMAGE_WIDTH;
    cfg_wdata      <= '0;
    mismatch_count = 0;
    right_carry    = 0;
    pend_down_left = 0;
    pend_down      = 0;
    col_pos        = 0;
    row_pos        = 0;
    foreach (below_err[i]) below_err[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_size();
    test_threshold_frame();
    test_zero_size();
    test_oversize_regs();
    test_tall_column();
    test_random_frames();

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS error_diffusion_dither_unit");
    end else begin
      $display("FAIL error_diffusion_dither_unit");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAIL error_diffusion_dither_unit");
    $finish;
  end

endmodule
